### rtl/core/bsme_pkg.sv
// Package for the byte stack machine executor.
// Holds default sizes, field widths, opcode and fault codes.
// No dependencies.
package bsme_pkg;

  // Default sizes
  localparam int unsigned STACK_BYTES_DEF = 4096;
  localparam int unsigned CALL_DEPTH_DEF  = 64;
  localparam int unsigned PC_BITS_DEF     = 16;

  // Fixed field widths
  localparam int unsigned OP_W    = 5;
  localparam int unsigned IMMA_W  = 64;
  localparam int unsigned IMMB_W  = 13;
  localparam int unsigned FAULT_W = 3;

  // Opcodes
  localparam logic [OP_W-1:0] OP_NOP  = 5'd0;
  localparam logic [OP_W-1:0] OP_PTC  = 5'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 5'd2;
  localparam logic [OP_W-1:0] OP_SUB  = 5'd3;
  localparam logic [OP_W-1:0] OP_MOD  = 5'd4;
  localparam logic [OP_W-1:0] OP_MUL  = 5'd5;
  localparam logic [OP_W-1:0] OP_DIV  = 5'd6;
  localparam logic [OP_W-1:0] OP_CLL  = 5'd7;
  localparam logic [OP_W-1:0] OP_RET  = 5'd8;
  localparam logic [OP_W-1:0] OP_TKS  = 5'd9;
  localparam logic [OP_W-1:0] OP_JMP  = 5'd10;
  localparam logic [OP_W-1:0] OP_JPT  = 5'd11;
  localparam logic [OP_W-1:0] OP_JPF  = 5'd12;
  localparam logic [OP_W-1:0] OP_EQU  = 5'd13;
  localparam logic [OP_W-1:0] OP_LT   = 5'd14;
  localparam logic [OP_W-1:0] OP_GT   = 5'd15;
  localparam logic [OP_W-1:0] OP_NOT  = 5'd16;
  localparam logic [OP_W-1:0] OP_OR   = 5'd17;
  localparam logic [OP_W-1:0] OP_EXT  = 5'd18;
  localparam logic [OP_W-1:0] OP_INC  = 5'd19;
  localparam logic [OP_W-1:0] OP_DEC  = 5'd20;
  localparam logic [OP_W-1:0] OP_PSH  = 5'd21;
  localparam logic [OP_W-1:0] OP_PS8  = 5'd22;
  localparam logic [OP_W-1:0] OP_DUP  = 5'd23;
  localparam logic [OP_W-1:0] OP_SWP  = 5'd24;
  localparam logic [OP_W-1:0] OP_DRP  = 5'd25;
  localparam logic [OP_W-1:0] OP_ROT  = 5'd26;
  localparam logic [OP_W-1:0] OP_OVR  = 5'd27;
  localparam logic [OP_W-1:0] OP_DRPZ = 5'd28;
  localparam logic [OP_W-1:0] OP_DUPZ = 5'd29;
  localparam logic [OP_W-1:0] OP_SWPZ = 5'd30;
  localparam logic [OP_W-1:0] OP_DBG  = 5'd31;

  // Fault codes
  localparam logic [FAULT_W-1:0] FLT_NONE   = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_STACK  = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_BOUND  = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_CALLOV = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_CALLEM = 3'd4;
  localparam logic [FAULT_W-1:0] FLT_DIVZ   = 3'd5;
  localparam logic [FAULT_W-1:0] FLT_OFFS   = 3'd6;

endpackage

### rtl/core/bsme_in_if.sv
// Instruction channel of the byte stack machine executor.
// Depends on bsme_pkg.
interface bsme_in_if import bsme_pkg::*; #(
  parameter int unsigned PC_BITS = PC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     action;
  logic [IMMA_W-1:0]   immediate_a;
  logic [IMMB_W-1:0]   immediate_b;
  logic [PC_BITS-1:0]  fall_through_pc;

  modport source (output valid, action, immediate_a, immediate_b, fall_through_pc,
                  input ready);
  modport sink   (input valid, action, immediate_a, immediate_b, fall_through_pc,
                  output ready);
endinterface

### rtl/core/bsme_out_if.sv
// Result channel of the byte stack machine executor.
// Depends on bsme_pkg.
interface bsme_out_if import bsme_pkg::*; #(
  parameter int unsigned PC_BITS = PC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [PC_BITS-1:0]  next_pc;
  logic                halted;
  logic                char_valid;
  logic [7:0]          char_out;
  logic                debug_valid;
  logic [IMMA_W-1:0]   debug_value;
  logic [FAULT_W-1:0]  fault;

  modport source (output valid, next_pc, halted, char_valid, char_out, debug_valid,
                  debug_value, fault, input ready);
  modport sink   (input valid, next_pc, halted, char_valid, char_out, debug_valid,
                  debug_value, fault, output ready);
endinterface

### rtl/core/bsme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/core/byte_stack_machine_executor_top.sv
// Byte stack machine executor: sequencer, byte stack RAM, frame RAMs.
// Depends on bsme_pkg, bsme_in_if, bsme_out_if and bsme_ram.
//
//  channel | dir | payload                                                | handshake
//  in_i    | in  | action, immediate_a, immediate_b, fall_through_pc      | valid/ready
//  out_o   | out | next_pc, halted, char_valid/out, debug_valid/value, fault | valid/ready
//
// One instruction at a time, in the steps accept, check, execute and hand-off; a fault found
// at the check skips execution. Popping adds a load step per byte loaded (up to 24) plus one,
// pushing a store step per byte stored (up to 24); mul, div and mod iterate on the shared
// shift-add/subtract unit; ret adds a frame restore; dupz copies ib bytes and swpz swaps
// n byte pairs over the byte-wide read and write ports of the stack RAM; tks walks frames.
// Reset clears pointer and handshake state and sets frame depth to 1; no clearing pass needed.
// A stalled result is held in the output register; the next instruction is taken
// meanwhile and waits at its end until the register frees.
module byte_stack_machine_executor_top import bsme_pkg::*; #(
  parameter int unsigned STACK_BYTES = STACK_BYTES_DEF,
  parameter int unsigned CALL_DEPTH  = CALL_DEPTH_DEF,
  parameter int unsigned PC_BITS     = PC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bsme_in_if.sink        in_i,
  bsme_out_if.source     out_o
);
  localparam int unsigned SPW = $clog2(STACK_BYTES + 1);
  localparam int unsigned AW  = $clog2(STACK_BYTES);
  localparam int unsigned IW  = $clog2(CALL_DEPTH);
  localparam int unsigned DW  = $clog2(CALL_DEPTH + 1);
  localparam int unsigned CW  = (SPW > IMMB_W) ? SPW : IMMB_W;
  localparam logic [SPW:0]  STACK_LIM  = (SPW + 1)'(STACK_BYTES);
  localparam logic [CW:0]   STACK_LIMC = (CW + 1)'(STACK_BYTES);
  localparam logic [DW-1:0] DEPTH_MAX  = DW'(CALL_DEPTH);

  // Sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CHECK   = 4'd1;
  localparam logic [3:0] ST_LOAD    = 4'd2;
  localparam logic [3:0] ST_OPCHK   = 4'd3;
  localparam logic [3:0] ST_ITER    = 4'd4;
  localparam logic [3:0] ST_STORE   = 4'd5;
  localparam logic [3:0] ST_COPY    = 4'd6;
  localparam logic [3:0] ST_SWAP    = 4'd7;
  localparam logic [3:0] ST_FRAME   = 4'd8;
  localparam logic [3:0] ST_TKS_RD  = 4'd9;
  localparam logic [3:0] ST_TKS_CMP = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  logic [3:0]          state_q, state_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [IMMA_W-1:0]   ia_q, ia_d;
  logic [IMMB_W-1:0]   ib_q, ib_d;
  logic [PC_BITS-1:0]  ft_q, ft_d;
  logic [SPW-1:0]      sp_q, sp_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic [SPW-1:0]      cs_q, cs_d;
  logic [191:0]        ld_q, ld_d;
  logic [191:0]        st_q, st_d;
  logic [4:0]          lcnt_q, lcnt_d;
  logic [4:0]          nstore_q, nstore_d;
  logic [SPW-1:0]      wbase_q, wbase_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [1:0]          ph_q, ph_d;
  logic [7:0]          tmp_q, tmp_d;
  logic [IW-1:0]       tidx_q, tidx_d;
  logic [SPW-1:0]      low_q, low_d;
  logic [64:0]         acc_q, acc_d;
  logic [63:0]         mb_q, mb_d;
  logic [63:0]         dvs_q, dvs_d;
  logic [5:0]          it_q, it_d;
  logic [PC_BITS-1:0]  rpc_q, rpc_d;
  logic                rhalt_q, rhalt_d, rcv_q, rcv_d, rdv_q, rdv_d;
  logic [7:0]          rch_q, rch_d;
  logic [63:0]         rdval_q, rdval_d;
  logic [FAULT_W-1:0]  rf_q, rf_d;
  logic                ov_q, ov_d;
  logic [PC_BITS-1:0]  opc_q, opc_d;
  logic                ohalt_q, ohalt_d, ocv_q, ocv_d, odv_q, odv_d;
  logic [7:0]          och_q, och_d;
  logic [63:0]         odval_q, odval_d;
  logic [FAULT_W-1:0]  of_q, of_d;

  // RAM ports
  logic                s_we;
  logic [AW-1:0]       s_waddr, s_raddr;
  logic [7:0]          s_wdata, s_rdata;
  logic                fr_we, fs_we;
  logic [IW-1:0]       fr_waddr, fr_raddr, fs_waddr, fs_raddr;
  logic [PC_BITS-1:0]  fr_wdata, fr_rdata;
  logic [SPW-1:0]      fs_wdata, fs_rdata;

  // Decode and checks
  logic [63:0]         pop_n;
  logic [4:0]          push_n, nload;
  logic [SPW-1:0]      room, spn;
  logic [FAULT_W-1:0]  gen_f, chk_f;
  logic [63:0]         w0, w1, w2;
  logic                is_div;
  logic [64:0]         shl, opnd;
  logic [65:0]         sum;
  logic [SPW-1:0]      ld_addr, st_addr;
  logic [CW-1:0]       ibc, nc, cp_src, cp_dst, sw_a0, sw_a1;
  logic [4:0]          lcnt_m1;

  bsme_ram #(.WIDTH(8), .DEPTH(STACK_BYTES)) u_stack_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );
  bsme_ram #(.WIDTH(PC_BITS), .DEPTH(CALL_DEPTH)) u_fret_ram (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );
  bsme_ram #(.WIDTH(SPW), .DEPTH(CALL_DEPTH)) u_fstart_ram (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );

  // Pop, push and load sizes per opcode
  always_comb begin
    pop_n  = '0;
    push_n = '0;
    nload  = '0;
    unique case (op_q)
      OP_PTC:                              begin pop_n = 64'd1;  nload = 5'd1; end
      OP_ADD, OP_SUB, OP_MOD, OP_MUL, OP_DIV:
        begin pop_n = 64'd16; push_n = 5'd8; nload = 5'd16; end
      OP_CLL, OP_TKS, OP_JMP, OP_DBG:      begin pop_n = 64'd8;  nload = 5'd8; end
      OP_JPT, OP_JPF:                      begin pop_n = 64'd9;  nload = 5'd9; end
      OP_EQU, OP_LT, OP_GT: begin pop_n = 64'd16; push_n = 5'd1; nload = 5'd16; end
      OP_NOT:               begin pop_n = 64'd1;  push_n = 5'd1; nload = 5'd1; end
      OP_OR:                begin pop_n = 64'd2;  push_n = 5'd1; nload = 5'd2; end
      OP_INC, OP_DEC:       begin pop_n = 64'd8;  push_n = 5'd8; nload = 5'd8; end
      OP_PSH:               push_n = 5'd8;
      OP_PS8:               push_n = 5'd1;
      OP_DUP:               begin pop_n = 64'd8;  push_n = 5'd16; nload = 5'd8; end
      OP_SWP:               begin pop_n = 64'd16; push_n = 5'd16; nload = 5'd16; end
      OP_DRP:               pop_n = 64'd8;
      OP_ROT:               begin pop_n = 64'd24; push_n = 5'd24; nload = 5'd24; end
      OP_OVR:               begin pop_n = 64'd16; push_n = 5'd24; nload = 5'd16; end
      OP_DRPZ:              pop_n = ia_q;
      default:              ;
    endcase
  end

  // Fault checks against frame bound and stack size
  always_comb begin
    room = (sp_q >= cs_q) ? sp_q - cs_q : '0;
    if (pop_n != '0 && depth_q == '0) begin
      gen_f = FLT_CALLEM;
    end else if (pop_n > 64'(room)) begin
      gen_f = FLT_BOUND;
    end else if (({1'b0, sp_q} - (SPW + 1)'(pop_n[SPW-1:0]) + (SPW + 1)'(push_n))
                 > STACK_LIM) begin
      gen_f = FLT_STACK;
    end else begin
      gen_f = FLT_NONE;
    end
    unique case (op_q)
      OP_NOP, OP_EXT: chk_f = FLT_NONE;
      OP_RET: chk_f = (depth_q == '0) ? FLT_CALLEM : FLT_NONE;
      OP_CLL: chk_f = (gen_f != FLT_NONE) ? gen_f :
                      (depth_q == DEPTH_MAX) ? FLT_CALLOV : FLT_NONE;
      OP_DUPZ: begin
        priority if (depth_q == '0)                        chk_f = FLT_CALLEM;
        else if (ia_q < 64'(ib_q))                         chk_f = FLT_OFFS;
        else if (ia_q > 64'(room))                         chk_f = FLT_BOUND;
        else if ((CW + 1)'(sp_q) + (CW + 1)'(ib_q) > STACK_LIMC) chk_f = FLT_STACK;
        else                                               chk_f = FLT_NONE;
      end
      OP_SWPZ: begin
        priority if (ia_q != '0 && depth_q == '0) chk_f = FLT_CALLEM;
        else if (ia_q > 64'(room >> 1))           chk_f = FLT_BOUND;
        else                                      chk_f = FLT_NONE;
      end
      default: chk_f = gen_f;
    endcase
  end

  // Operand words and the shared shift-add/subtract unit
  always_comb begin
    w0     = ld_q[63:0];
    w1     = ld_q[127:64];
    w2     = ld_q[191:128];
    spn    = sp_q - SPW'(8);
    is_div = (op_q == OP_DIV) || (op_q == OP_MOD);
    shl    = {acc_q[63:0], is_div ? mb_q[63] : 1'b0};
    opnd   = is_div ? ~{1'b0, dvs_q} : (mb_q[63] ? {1'b0, dvs_q} : 65'd0);
    sum    = {1'b0, shl} + {1'b0, opnd} + 66'(is_div);
  end

  // Byte addresses
  always_comb begin
    lcnt_m1 = lcnt_q - 5'd1;
    ld_addr = sp_q - SPW'(nload) + SPW'(lcnt_q);
    st_addr = wbase_q + SPW'(lcnt_q);
    ibc     = CW'(ib_q);
    nc      = CW'(ia_q[SPW-1:0]);
    cp_src  = CW'(wbase_q) + cnt_q;
    cp_dst  = CW'(sp_q) + cnt_q - CW'(1);
    sw_a0   = CW'(wbase_q) + cnt_q;
    sw_a1   = CW'(wbase_q) + nc + cnt_q;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;  op_d = op_q;  ia_d = ia_q;  ib_d = ib_q;  ft_d = ft_q;
    sp_d = sp_q;  depth_d = depth_q;  cs_d = cs_q;  ld_d = ld_q;  st_d = st_q;
    lcnt_d = lcnt_q;  nstore_d = nstore_q;  wbase_d = wbase_q;  cnt_d = cnt_q;
    ph_d = ph_q;  tmp_d = tmp_q;  tidx_d = tidx_q;  low_d = low_q;
    acc_d = acc_q;  mb_d = mb_q;  dvs_d = dvs_q;  it_d = it_q;
    rpc_d = rpc_q;  rhalt_d = rhalt_q;  rcv_d = rcv_q;  rch_d = rch_q;
    rdv_d = rdv_q;  rdval_d = rdval_q;  rf_d = rf_q;
    ov_d = ov_q & ~out_o.ready;
    opc_d = opc_q;  ohalt_d = ohalt_q;  ocv_d = ocv_q;  och_d = och_q;
    odv_d = odv_q;  odval_d = odval_q;  of_d = of_q;
    s_we = 1'b0;  s_waddr = '0;  s_wdata = '0;  s_raddr = '0;
    fr_we = 1'b0;  fr_waddr = '0;  fr_wdata = '0;  fr_raddr = '0;
    fs_we = 1'b0;  fs_waddr = '0;  fs_wdata = '0;  fs_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        // Take a transaction and clear the result
        if (in_i.valid) begin
          op_d = in_i.action;  ia_d = in_i.immediate_a;  ib_d = in_i.immediate_b;
          ft_d = in_i.fall_through_pc;
          rpc_d = in_i.fall_through_pc;  rhalt_d = 1'b0;  rcv_d = 1'b0;  rch_d = '0;
          rdv_d = 1'b0;  rdval_d = '0;  rf_d = FLT_NONE;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        lcnt_d = '0;
        if (chk_f != FLT_NONE) begin
          rf_d = chk_f;
          state_d = ST_DONE;
        end else begin
          rhalt_d = (op_q == OP_EXT);
          state_d = (nload != '0) ? ST_LOAD : ST_OPCHK;
        end
      end
      ST_LOAD: begin
        // Read popped bytes, lowest address first
        s_raddr = ld_addr[AW-1:0];
        if (lcnt_q != '0) begin
          ld_d[8*lcnt_m1 +: 8] = s_rdata;
        end
        if (lcnt_q == nload) begin
          state_d = ST_OPCHK;
        end else begin
          lcnt_d = lcnt_q + 5'd1;
        end
      end
      ST_OPCHK: begin
        lcnt_d  = '0;
        cnt_d   = '0;
        ph_d    = '0;
        state_d = ST_DONE;
        unique case (op_q)
          OP_PTC: begin rch_d = w0[7:0]; rcv_d = 1'b1; sp_d = sp_q - SPW'(1); end
          OP_DBG: begin rdval_d = w0; rdv_d = 1'b1; sp_d = spn; end
          OP_DRP: sp_d = spn;
          OP_JMP: begin rpc_d = w0[PC_BITS-1:0]; sp_d = spn; end
          OP_JPT, OP_JPF: begin
            if ((op_q == OP_JPT) == (ld_q[7:0] != 8'd0)) rpc_d = ld_q[8 +: PC_BITS];
            sp_d = sp_q - SPW'(9);
          end
          OP_ADD, OP_SUB: begin
            st_d[63:0] = (op_q == OP_ADD) ? w0 + w1 : w0 - w1;
            nstore_d = 5'd8;  wbase_d = sp_q - SPW'(16);  sp_d = spn;
            state_d = ST_STORE;
          end
          OP_MUL, OP_DIV, OP_MOD: begin
            if (is_div && w1 == '0) begin
              rf_d = FLT_DIVZ;
            end else begin
              acc_d = '0;  mb_d = w0;  dvs_d = w1;  it_d = '0;
              nstore_d = 5'd8;  wbase_d = sp_q - SPW'(16);  sp_d = spn;
              state_d = ST_ITER;
            end
          end
          OP_EQU, OP_LT, OP_GT: begin
            st_d[7:0] = {7'd0, (op_q == OP_EQU) ? (w0 == w1) :
                               (op_q == OP_LT) ? (w0 < w1) : (w0 > w1)};
            nstore_d = 5'd1;  wbase_d = sp_q - SPW'(16);  sp_d = sp_q - SPW'(15);
            state_d = ST_STORE;
          end
          OP_NOT: begin
            st_d[7:0] = {7'd0, ld_q[7:0] == 8'd0};
            nstore_d = 5'd1;  wbase_d = sp_q - SPW'(1);
            state_d = ST_STORE;
          end
          OP_OR: begin
            st_d[7:0] = {7'd0, (ld_q[7:0] != 8'd0) || (ld_q[15:8] != 8'd0)};
            nstore_d = 5'd1;  wbase_d = sp_q - SPW'(2);  sp_d = sp_q - SPW'(1);
            state_d = ST_STORE;
          end
          OP_INC, OP_DEC: begin
            st_d[63:0] = (op_q == OP_INC) ? w0 + 64'd1 : w0 - 64'd1;
            nstore_d = 5'd8;  wbase_d = spn;
            state_d = ST_STORE;
          end
          OP_PSH, OP_PS8, OP_DUP: begin
            st_d[63:0] = (op_q == OP_DUP) ? w0 : ia_q;
            nstore_d = (op_q == OP_PS8) ? 5'd1 : 5'd8;
            wbase_d = sp_q;  sp_d = sp_q + SPW'(nstore_d);
            state_d = ST_STORE;
          end
          OP_SWP: begin
            st_d[127:0] = {w0, w1};
            nstore_d = 5'd16;  wbase_d = sp_q - SPW'(16);
            state_d = ST_STORE;
          end
          OP_ROT: begin
            st_d = {w0, w2, w1};
            nstore_d = 5'd24;  wbase_d = sp_q - SPW'(24);
            state_d = ST_STORE;
          end
          OP_OVR: begin
            st_d = {w0, w1, w0};
            nstore_d = 5'd24;  wbase_d = sp_q - SPW'(16);  sp_d = sp_q + SPW'(8);
            state_d = ST_STORE;
          end
          OP_CLL: begin
            fr_we = 1'b1;  fr_waddr = depth_q[IW-1:0];  fr_wdata = ft_q;
            fs_we = 1'b1;  fs_waddr = depth_q[IW-1:0];  fs_wdata = spn;
            depth_d = depth_q + DW'(1);  cs_d = spn;  sp_d = spn;
            rpc_d = w0[PC_BITS-1:0];
          end
          OP_RET: begin
            fr_raddr = IW'(depth_q - DW'(1));
            fs_raddr = IW'(depth_q - DW'(2));
            depth_d = depth_q - DW'(1);
            state_d = ST_FRAME;
          end
          OP_TKS: begin
            if (w0 > 64'(spn) || spn != cs_q) begin
              rf_d = FLT_BOUND;
            end else begin
              sp_d  = spn;
              low_d = spn - w0[SPW-1:0];
              tidx_d = IW'(depth_q - DW'(1));
              if (depth_q > DW'(1)) state_d = ST_TKS_RD;
            end
          end
          OP_DRPZ: sp_d = sp_q - ia_q[SPW-1:0];
          OP_DUPZ: begin
            wbase_d = sp_q - ia_q[SPW-1:0];
            state_d = ST_COPY;
          end
          OP_SWPZ: begin
            wbase_d = sp_q - {ia_q[SPW-2:0], 1'b0};
            state_d = ST_SWAP;
          end
          default: ;
        endcase
      end
      ST_ITER: begin
        // One bit of multiply or divide per cycle
        if (is_div) begin
          acc_d = sum[65] ? sum[64:0] : shl;
          mb_d  = {mb_q[62:0], sum[65]};
        end else begin
          acc_d = sum[64:0];
          mb_d  = {mb_q[62:0], 1'b0};
        end
        it_d = it_q + 6'd1;
        if (it_q == 6'd63) begin
          st_d[63:0] = (op_q == OP_DIV) ? mb_d : acc_d[63:0];
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        s_we = 1'b1;
        s_waddr = st_addr[AW-1:0];
        s_wdata = st_q[8*lcnt_q +: 8];
        if (lcnt_q == nstore_q - 5'd1) begin
          state_d = ST_DONE;
        end else begin
          lcnt_d = lcnt_q + 5'd1;
        end
      end
      ST_COPY: begin
        // Read source byte, write the previous one
        s_raddr = cp_src[AW-1:0];
        if (cnt_q != '0) begin
          s_we = 1'b1;  s_waddr = cp_dst[AW-1:0];  s_wdata = s_rdata;
        end
        if (cnt_q == ibc) begin
          sp_d = sp_q + SPW'(ib_q);
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_SWAP: begin
        unique case (ph_q)
          2'd0: begin
            if (cnt_q == nc) begin
              state_d = ST_DONE;
            end else begin
              s_raddr = sw_a0[AW-1:0];  ph_d = 2'd1;
            end
          end
          2'd1: begin
            tmp_d = s_rdata;  s_raddr = sw_a1[AW-1:0];  ph_d = 2'd2;
          end
          2'd2: begin
            s_we = 1'b1;  s_waddr = sw_a0[AW-1:0];  s_wdata = s_rdata;  ph_d = 2'd3;
          end
          default: begin
            s_we = 1'b1;  s_waddr = sw_a1[AW-1:0];  s_wdata = tmp_q;
            cnt_d = cnt_q + CW'(1);  ph_d = 2'd0;
          end
        endcase
      end
      ST_FRAME: begin
        // Restore return address and caller frame start
        rpc_d = (depth_q == '0) ? '0 : fr_rdata;
        cs_d  = (depth_q <= DW'(1)) ? '0 : fs_rdata;
        state_d = ST_DONE;
      end
      ST_TKS_RD: begin
        fs_raddr = tidx_q;
        state_d = ST_TKS_CMP;
      end
      ST_TKS_CMP: begin
        // Lower frame starts until one already sits at or below the new base
        state_d = ST_DONE;
        if (low_q < fs_rdata) begin
          fs_we = 1'b1;  fs_waddr = tidx_q;  fs_wdata = low_q;
          if (tidx_q == IW'(depth_q - DW'(1))) cs_d = low_q;
          if (tidx_q != IW'(1)) begin
            tidx_d = tidx_q - IW'(1);
            state_d = ST_TKS_RD;
          end
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;  opc_d = rpc_q;  ohalt_d = rhalt_q;  ocv_d = rcv_q;
          och_d = rch_q;  odv_d = rdv_q;  odval_d = rdval_q;  of_d = rf_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sp_q    <= '0;
      depth_q <= DW'(1);
      cs_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      depth_q <= depth_d;
      cs_q    <= cs_d;
      ov_q    <= ov_d;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d;  ia_q <= ia_d;  ib_q <= ib_d;  ft_q <= ft_d;
    ld_q <= ld_d;  st_q <= st_d;  lcnt_q <= lcnt_d;  nstore_q <= nstore_d;
    wbase_q <= wbase_d;  cnt_q <= cnt_d;  ph_q <= ph_d;  tmp_q <= tmp_d;
    tidx_q <= tidx_d;  low_q <= low_d;  acc_q <= acc_d;  mb_q <= mb_d;
    dvs_q <= dvs_d;  it_q <= it_d;
    rpc_q <= rpc_d;  rhalt_q <= rhalt_d;  rcv_q <= rcv_d;  rch_q <= rch_d;
    rdv_q <= rdv_d;  rdval_q <= rdval_d;  rf_q <= rf_d;
    opc_q <= opc_d;  ohalt_q <= ohalt_d;  ocv_q <= ocv_d;  och_q <= och_d;
    odv_q <= odv_d;  odval_q <= odval_d;  of_q <= of_d;
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.next_pc     = opc_q;
  assign out_o.halted      = ohalt_q;
  assign out_o.char_valid  = ocv_q;
  assign out_o.char_out    = och_q;
  assign out_o.debug_valid = odv_q;
  assign out_o.debug_value = odval_q;
  assign out_o.fault       = of_q;
endmodule

### rtl/core/bsme_checker.sv
// Port-level checks for the byte stack machine executor.
// Depends on bsme_pkg; bound to byte_stack_machine_executor_top.
module bsme_checker import bsme_pkg::*; #(
  parameter int unsigned PC_BITS = PC_BITS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PC_BITS-1:0] next_pc,
  input logic               halted,
  input logic               char_valid,
  input logic               debug_valid,
  input logic [FAULT_W-1:0] fault
);
  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(fault))
    else $error("stalled result changed");

  // One instruction in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // A faulting transaction emits nothing
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && fault != FLT_NONE |-> !halted && !char_valid && !debug_valid)
    else $error("fault with side output");

  // Fault code range
  a_fault_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> fault <= FLT_OFFS)
    else $error("fault code out of range");

  // At most one kind of output per transaction
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> $onehot0({halted, char_valid, debug_valid}))
    else $error("several output kinds at once");
endmodule

bind byte_stack_machine_executor_top bsme_checker #(.PC_BITS(PC_BITS)) u_bsme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .next_pc     (out_o.next_pc),
  .halted      (out_o.halted),
  .char_valid  (out_o.char_valid),
  .debug_valid (out_o.debug_valid),
  .fault       (out_o.fault)
);
